/* sv/collision_impulse_response_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the collision impulse response block
// Implication checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef COLLISION_IMPULSE_RESPONSE_TOP_ASSERT_SVH
`define COLLISION_IMPULSE_RESPONSE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CIR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cir assertion failed");
// next-cycle implication
`define CIR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cir assertion failed");
`else
`define CIR_ASSERT_IMP(label, ante, cons)
`define CIR_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* sv/cir_pkg.sv */
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, constants and saturation helper for the impulse pipeline.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int QW = 32;                    // quotient bits of each divider
  localparam logic [17:0] E_ONE = 18'd65536; // restitution of one, Q1.16
  localparam int E_W = 17;                   // restitution register width

  // one contact pair as it travels down the pipeline
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic               deg;
  } item_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/cir_div.sv */
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module cir_div #(
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [31:0]   hi,
  input  logic [31:0]   lo,
  input  logic [31:0]   den,
  input  logic [PW-1:0] pay,
  output logic          out_vld,
  output logic [31:0]   quo,
  output logic [PW-1:0] out_pay
);

  localparam int NS = cir_pkg::QW;

  logic          vld   [NS];
  logic [31:0]   rem   [NS];
  logic [31:0]   low   [NS];
  logic [31:0]   quo_s [NS];
  logic [31:0]   dvs   [NS];
  logic [PW-1:0] pl    [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          v_i;
    logic [31:0]   r_i;
    logic [31:0]   l_i;
    logic [31:0]   q_i;
    logic [31:0]   d_i;
    logic [PW-1:0] p_i;
    logic [32:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i = in_vld;
      assign r_i = hi;
      assign l_i = lo;
      assign q_i = '0;
      assign d_i = den;
      assign p_i = pay;
    end else begin : g_rest
      assign v_i = vld[k-1];
      assign r_i = rem[k-1];
      assign l_i = low[k-1];
      assign q_i = quo_s[k-1];
      assign d_i = dvs[k-1];
      assign p_i = pl[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_i, l_i[31]};
    assign ge    = trial >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? 32'(trial - {1'b0, d_i}) : trial[31:0];
        low[k]   <= {l_i[30:0], 1'b0};
        quo_s[k] <= {q_i[30:0], ge};
        dvs[k]   <= d_i;
        pl[k]    <= p_i;
      end
    end
  end

  assign out_vld = vld[NS-1];
  assign quo     = quo_s[NS-1];
  assign out_pay = pl[NS-1];

endmodule

/* sv/cir_front.sv */
// ----------------------------------------------------------------------------
// cir_front
// Velocity difference, dot products, restitution scaling, divider setup.
// ----------------------------------------------------------------------------
module cir_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  cir_pkg::item_t      item,
  input  logic [16:0]         rest,
  output logic                out_vld,
  output cir_pkg::item_t      out_item,
  output logic [31:0]         div_hi,
  output logic [31:0]         div_lo,
  output logic [31:0]         div_den,
  output logic                sneg,
  output logic                ovf
);

  // stage 1: difference of velocities, clamp restitution
  logic               v1;
  cir_pkg::item_t     it1;
  logic signed [31:0] dvx1, dvy1;
  logic [17:0]        fac1;
  logic signed [65:0] dx, dy;
  logic [17:0]        e_sat;

  assign dx    = $signed(item.vax) - $signed(item.vbx);
  assign dy    = $signed(item.vay) - $signed(item.vby);
  assign e_sat = ({1'b0, rest} > cir_pkg::E_ONE) ? cir_pkg::E_ONE : {1'b0, rest};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1  <= item;
      dvx1 <= cir_pkg::sat32(dx);
      dvy1 <= cir_pkg::sat32(dy);
      fac1 <= cir_pkg::E_ONE + e_sat;
    end
  end

  // stage 2: four products
  logic               v2;
  cir_pkg::item_t     it2;
  logic [17:0]        fac2;
  logic signed [63:0] pdx2, pdy2, pnx2, pny2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2  <= it1;
      fac2 <= fac1;
      pdx2 <= dvx1 * $signed(it1.nx);
      pdy2 <= dvy1 * $signed(it1.ny);
      pnx2 <= $signed(it1.nx) * $signed(it1.nx);
      pny2 <= $signed(it1.ny) * $signed(it1.ny);
    end
  end

  // stage 3: floor shift and sum, flag zero masses and zero denominators
  logic               v3;
  cir_pkg::item_t     it3;
  cir_pkg::item_t     it2_flag;
  logic [17:0]        fac3;
  logic signed [31:0] dot3;
  logic [31:0]        nn3;
  logic signed [63:0] sdx, sdy, snx, sny;
  logic signed [65:0] sdot, snn;
  logic signed [31:0] nn_sat;

  assign sdx    = pdx2 >>> FRAC_BITS;
  assign sdy    = pdy2 >>> FRAC_BITS;
  assign snx    = pnx2 >>> FRAC_BITS;
  assign sny    = pny2 >>> FRAC_BITS;
  assign sdot   = sdx + sdy;
  assign snn    = snx + sny;
  assign nn_sat = cir_pkg::sat32(snn);

  always_comb begin
    it2_flag     = it2;
    it2_flag.deg = (it2.ma == '0) || (it2.mb == '0) || (nn_sat == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it3  <= it2_flag;
      fac3 <= fac2;
      dot3 <= cir_pkg::sat32(sdot);
      nn3  <= nn_sat;
    end
  end

  // stage 4: scale by (1 + e)
  logic               v4;
  cir_pkg::item_t     it4;
  logic [31:0]        nn4;
  logic signed [49:0] p4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it4 <= it3;
      nn4 <= nn3;
      p4  <= dot3 * $signed({1'b0, fac3});
    end
  end

  // stage 5: negate, drop the fraction of the Q2.16 factor, split into divider halves
  logic signed [50:0] negp, shf;
  logic signed [34:0] s5;
  logic [34:0]        mag;
  logic [63:0]        dvd;

  assign negp = -p4;
  assign shf  = negp >>> 16;
  assign s5   = shf[34:0];
  assign mag  = s5[34] ? (~s5 + 35'd1) : s5;
  assign dvd  = {29'd0, mag} << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= it4;
      div_hi   <= dvd[63:32];
      div_lo   <= dvd[31:0];
      div_den  <= nn4;
      sneg     <= s5[34];
      ovf      <= dvd >= {nn4, 32'd0};
    end
  end

endmodule

/* sv/cir_mid.sv */
// ----------------------------------------------------------------------------
// cir_mid
// Saturate the impulse quotient and form mass-weighted dividends.
// ----------------------------------------------------------------------------
module cir_mid (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [31:0]    quo,
  input  cir_pkg::item_t item,
  input  logic           sneg,
  input  logic           ovf,
  output logic           out_vld,
  output cir_pkg::item_t out_item,
  output logic           tneg,
  output logic [31:0]    tmag,
  output logic [31:0]    hi_a,
  output logic [31:0]    lo_a,
  output logic [31:0]    hi_b,
  output logic [31:0]    lo_b,
  output logic [31:0]    msum
);

  localparam logic [31:0] MAG_POS = 32'h7fffffff;
  localparam logic [31:0] MAG_NEG = 32'h80000000;

  // stage 6: clamp |t|
  logic           v6;
  cir_pkg::item_t it6;
  logic           tneg6;
  logic [31:0]    tmag6;
  logic [31:0]    mag_c;

  always_comb begin
    if (ovf) begin
      mag_c = sneg ? MAG_NEG : MAG_POS;
    end else if (sneg) begin
      mag_c = (quo > MAG_NEG) ? MAG_NEG : quo;
    end else begin
      mag_c = (quo > MAG_POS) ? MAG_POS : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it6   <= item;
      tneg6 <= sneg;
      tmag6 <= mag_c;
    end
  end

  // stage 7: |t| times the other mass, mass sum
  logic [62:0] pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= it6;
      tneg     <= tneg6;
      tmag     <= tmag6;
      pa       <= tmag6 * it6.mb;
      pb       <= tmag6 * it6.ma;
      msum     <= {1'b0, it6.ma} + {1'b0, it6.mb};
    end
  end

  assign hi_a = {1'b0, pa[62:32]};
  assign lo_a = pa[31:0];
  assign hi_b = {1'b0, pb[62:32]};
  assign lo_b = pb[31:0];

endmodule

/* sv/cir_back.sv */
// ----------------------------------------------------------------------------
// cir_back
// Signed velocity changes, projection on the normal, saturating update.
// ----------------------------------------------------------------------------
module cir_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        qa,
  input  logic [31:0]        qb,
  input  cir_pkg::item_t     item,
  input  logic [31:0]        tmag,
  input  logic               tneg,
  output logic               out_vld,
  output logic signed [31:0] nvax,
  output logic signed [31:0] nvay,
  output logic signed [31:0] nvbx,
  output logic signed [31:0] nvby,
  output logic               deg
);

  // stage 8: apply sign of t
  logic               v8;
  cir_pkg::item_t     it8;
  logic               tneg8;
  logic signed [32:0] ka8, kb8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it8   <= item;
      tneg8 <= tneg;
      ka8   <= tneg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
      kb8   <= tneg ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
    end
  end

  // stage 9: project on the normal
  logic               v9;
  cir_pkg::item_t     it9;
  logic signed [64:0] pax9, pay9, pbx9, pby9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it9  <= it8;
      pax9 <= ka8 * $signed(it8.nx);
      pay9 <= ka8 * $signed(it8.ny);
      pbx9 <= kb8 * $signed(it8.nx);
      pby9 <= kb8 * $signed(it8.ny);
    end
  end

  // stage 10: update and saturate, pass velocities through on a degenerate pair
  logic signed [65:0] sax, say, sbx, sby;

  assign sax = $signed(it9.vax) + (pax9 >>> FRAC_BITS);
  assign say = $signed(it9.vay) + (pay9 >>> FRAC_BITS);
  assign sbx = $signed(it9.vbx) - (pbx9 >>> FRAC_BITS);
  assign sby = $signed(it9.vby) - (pby9 >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg <= it9.deg;
      if (it9.deg) begin
        nvax <= it9.vax;
        nvay <= it9.vay;
        nvbx <= it9.vbx;
        nvby <= it9.vby;
      end else begin
        nvax <= cir_pkg::sat32(sax);
        nvay <= cir_pkg::sat32(say);
        nvbx <= cir_pkg::sat32(sbx);
        nvby <= cir_pkg::sat32(sby);
      end
    end
  end

  `include "collision_impulse_response_top_assert.svh"

  // the two floored shares never exceed the whole impulse
  `CIR_ASSERT_IMP(a_share_sum, in_vld && !item.deg, ({1'b0, qa} + {1'b0, qb}) <= {1'b0, tmag})
  // a negative impulse never yields a positive change for body A
  `CIR_ASSERT_IMP(a_sign_a, v8 && !it8.deg && tneg8, ka8 <= 0)
  // a zero change projects to zero
  `CIR_ASSERT_NXT(a_zero_proj, en && v8 && ka8 == 0, pax9 == 0 && pay9 == 0)

endmodule

/* sv/collision_impulse_response_top.sv */
// ----------------------------------------------------------------------------
// collision_impulse_response_top
// 2D impulse collision response for one contact pair per transaction.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   --------  ----------------------  ----------------------------------------
//   in        in_valid / in_ready     vel_a_x/y, vel_b_x/y, mass_a/b, normal_x/y
//   out       out_valid / out_ready   new_vel_a_x/y, new_vel_b_x/y, degenerate
//   cfg       cfg_valid / cfg_ready   cfg_data (restitution, Q1.16)
//
// One transaction per cycle sustained while out_ready is high; the path runs
// through 5 front stages, a 32-stage divider for the impulse, 2 stages for its
// clamp and the mass products, two 32-stage dividers side by side for the mass
// shares, and 3 back stages.
// Reset clears every stage valid bit and sets restitution to zero.
// The whole pipeline holds when the output register is full and not taken,
// so in_ready is low only then; no transaction is dropped or repeated.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module collision_impulse_response_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic [30:0]        mass_a,
  input  logic [30:0]        mass_b,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_vel_a_x,
  output logic signed [31:0] new_vel_a_y,
  output logic signed [31:0] new_vel_b_x,
  output logic signed [31:0] new_vel_b_y,
  output logic               degenerate
);

  localparam int PW1 = $bits(cir_pkg::item_t) + 2;
  localparam int PWA = $bits(cir_pkg::item_t) + 32;

  // advance every stage unless the output register holds an untaken result
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // restitution register, written whenever a config transaction lands
  logic [cir_pkg::E_W-1:0] restitution;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= '0;
    end else if (cfg_valid && cfg_ready) begin
      restitution <= cfg_data;
    end
  end

  cir_pkg::item_t in_item;
  always_comb begin
    in_item.vax = vel_a_x;
    in_item.vay = vel_a_y;
    in_item.vbx = vel_b_x;
    in_item.vby = vel_b_y;
    in_item.nx  = normal_x;
    in_item.ny  = normal_y;
    in_item.ma  = mass_a;
    in_item.mb  = mass_b;
    in_item.deg = 1'b0;
  end

  // front: dot products, scaling, divider operands
  logic           f_vld, f_sneg, f_ovf;
  cir_pkg::item_t f_item;
  logic [31:0]    f_hi, f_lo, f_den;

  cir_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid && in_ready),
    .item     (in_item),
    .rest     (restitution),
    .out_vld  (f_vld),
    .out_item (f_item),
    .div_hi   (f_hi),
    .div_lo   (f_lo),
    .div_den  (f_den),
    .sneg     (f_sneg),
    .ovf      (f_ovf)
  );

  // impulse divide: |s| * 2^F / (n.n)
  logic           d1_vld;
  logic [31:0]    d1_quo;
  logic [PW1-1:0] d1_pay;
  cir_pkg::item_t d1_item;
  logic           d1_sneg, d1_ovf;

  cir_div #(.PW(PW1)) u_div_t (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .hi      (f_hi),
    .lo      (f_lo),
    .den     (f_den),
    .pay     ({f_item, f_sneg, f_ovf}),
    .out_vld (d1_vld),
    .quo     (d1_quo),
    .out_pay (d1_pay)
  );

  assign {d1_item, d1_sneg, d1_ovf} = d1_pay;

  // clamp t, mass products
  logic           m_vld, m_tneg;
  cir_pkg::item_t m_item;
  logic [31:0]    m_tmag, m_hi_a, m_lo_a, m_hi_b, m_lo_b, m_msum;

  cir_mid u_mid (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d1_vld),
    .quo      (d1_quo),
    .item     (d1_item),
    .sneg     (d1_sneg),
    .ovf      (d1_ovf),
    .out_vld  (m_vld),
    .out_item (m_item),
    .tneg     (m_tneg),
    .tmag     (m_tmag),
    .hi_a     (m_hi_a),
    .lo_a     (m_lo_a),
    .hi_b     (m_hi_b),
    .lo_b     (m_lo_b),
    .msum     (m_msum)
  );

  // mass shares: |t|*mB/(mA+mB) and |t|*mA/(mA+mB), run side by side
  logic           da_vld, db_vld;
  logic [31:0]    da_quo, db_quo;
  logic [PWA-1:0] da_pay;
  cir_pkg::item_t da_item;
  logic [31:0]    da_tmag;
  logic           db_tneg;

  cir_div #(.PW(PWA)) u_div_a (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (m_vld),
    .hi      (m_hi_a),
    .lo      (m_lo_a),
    .den     (m_msum),
    .pay     ({m_item, m_tmag}),
    .out_vld (da_vld),
    .quo     (da_quo),
    .out_pay (da_pay)
  );

  cir_div #(.PW(1)) u_div_b (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (m_vld),
    .hi      (m_hi_b),
    .lo      (m_lo_b),
    .den     (m_msum),
    .pay     (m_tneg),
    .out_vld (db_vld),
    .quo     (db_quo),
    .out_pay (db_tneg)
  );

  assign {da_item, da_tmag} = da_pay;

  // back: apply shares along the normal, output register
  cir_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (da_vld && db_vld),
    .qa      (da_quo),
    .qb      (db_quo),
    .item    (da_item),
    .tmag    (da_tmag),
    .tneg    (db_tneg),
    .out_vld (out_valid),
    .nvax    (new_vel_a_x),
    .nvay    (new_vel_a_y),
    .nvbx    (new_vel_b_x),
    .nvby    (new_vel_b_y),
    .deg     (degenerate)
  );

endmodule
